### hdl/homophonic_cipher_codec_top_macros.svh
`ifndef HOMOPHONIC_CIPHER_CODEC_TOP_MACROS_SVH
`define HOMOPHONIC_CIPHER_CODEC_TOP_MACROS_SVH

// same-cycle implication, checked while out of reset
`define HCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define HCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/hcc_pkg.sv
`default_nettype none

package hcc_pkg;

  // field widths
  localparam int unsigned LETTER_W     = 16;
  localparam int unsigned CODE_W       = 10;
  localparam int unsigned RND_W        = 31;
  localparam int unsigned LETTER_OUT_W = 9;
  localparam int unsigned KEY_LEN_W    = 5;
  localparam int unsigned CFG_DATA_W   = 60;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned KEY_LOW_W    = 60;
  localparam int unsigned KEY_MID_W    = 60;
  localparam int unsigned KEY_HIGH_W   = 48;

  // alphabet and code space
  localparam int unsigned ALPHA_N  = 35;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned BLK_W    = 5;
  localparam int unsigned KEY_MAX  = 28;
  localparam int unsigned CODE_MAX = 999;
  localparam int unsigned KEY_LEN_RESET = 2;

  // letters up to this index own 29 codes, the rest 28
  localparam int unsigned P_SPLIT = 19;
  localparam int unsigned MOD_HI  = 29;
  localparam int unsigned MOD_LO  = 28;
  localparam int unsigned TOP_HI  = MOD_HI - 1;
  localparam int unsigned TOP_LO  = MOD_LO - 1;

  // random word residue: nibble weights 16^i mod n, then fold 64 mod n
  localparam int unsigned NIB_N  = 8;
  localparam int unsigned PAD_W  = NIB_N * 4;
  localparam int unsigned SUM_W  = 11;
  localparam int unsigned FOLD_W = 7;
  localparam int unsigned T_W    = 8;
  localparam int unsigned FOLD29 = 6;
  localparam int unsigned FOLD28 = 8;

  localparam logic [4:0] W29 [NIB_N] = '{5'd1, 5'd16, 5'd24, 5'd7, 5'd25, 5'd23, 5'd20, 5'd1};
  localparam logic [4:0] W28 [NIB_N] = '{5'd1, 5'd16, 5'd4, 5'd8, 5'd16, 5'd4, 5'd8, 5'd16};

  // code / 35 as (code * 937) >> 15, exact over 10-bit codes
  localparam int unsigned RECIP_35    = 937;
  localparam int unsigned RECIP_SHIFT = 15;
  localparam int unsigned PROD_W      = 2 * CODE_W;

  localparam logic [LETTER_W-1:0] ALPHA [ALPHA_N] = '{
    16'h0061, 16'h0105, 16'h0062, 16'h0063, 16'h0107, 16'h0064, 16'h0065,
    16'h0119, 16'h0066, 16'h0067, 16'h0068, 16'h0069, 16'h006a, 16'h006b,
    16'h006c, 16'h0142, 16'h006d, 16'h006e, 16'h0144, 16'h006f, 16'h00f3,
    16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h015b, 16'h0074, 16'h0075,
    16'h0076, 16'h0077, 16'h0078, 16'h0079, 16'h007a, 16'h017a, 16'h017c
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LENGTH = 2'd0,
    CFG_KEY_LOW    = 2'd1,
    CFG_KEY_MID    = 2'd2,
    CFG_KEY_HIGH   = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    FUNC_ENCRYPT = 1'b0,
    FUNC_DECRYPT = 1'b1
  } func_e;

  typedef struct packed {
    logic                func;
    logic [LETTER_W-1:0] letter_in;
    logic [CODE_W-1:0]   code_in;
    logic [RND_W-1:0]    random_word;
  } item_t;

  typedef struct packed {
    logic [KEY_LEN_W-1:0]            len;
    logic [KEY_MAX-1:0][IDX_W-1:0]   letters;
  } key_t;

  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
  } en_t;

  typedef struct packed {
    logic              valid;
    logic              func;
    logic [IDX_W-1:0]  p;
    logic              sel29;
    logic [SUM_W-1:0]  s29;
    logic [SUM_W-1:0]  s28;
    logic [BLK_W-1:0]  m_dec;
    logic [CODE_W-1:0] code;
  } stage_a_t;

  typedef struct packed {
    logic              valid;
    logic              func;
    logic [IDX_W-1:0]  p;
    logic              sel29;
    logic [FOLD_W-1:0] f29;
    logic [FOLD_W-1:0] f28;
    logic [BLK_W-1:0]  m_dec;
    logic [IDX_W-1:0]  j;
  } stage_b_t;

  typedef struct packed {
    logic             valid;
    logic             func;
    logic [BLK_W-1:0] m;
    logic [IDX_W-1:0] pos;
  } stage_c_t;

  typedef struct packed {
    logic             valid;
    logic             func;
    logic [BLK_W-1:0] m;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] k;
    logic             keyed;
  } stage_d_t;

  typedef struct packed {
    logic                    valid;
    logic                    func;
    logic [CODE_W-1:0]       code;
    logic [LETTER_OUT_W-1:0] letter;
  } res_t;

endpackage

`default_nettype wire

### hdl/hcc_if.sv
`default_nettype none

interface hcc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [hcc_pkg::LETTER_W-1:0] letter_in;
  logic [hcc_pkg::CODE_W-1:0]   code_in;
  logic [hcc_pkg::RND_W-1:0]    random_word;

  modport source (output valid, func, letter_in, code_in, random_word, input ready);
  modport sink   (input valid, func, letter_in, code_in, random_word, output ready);
endinterface

interface hcc_out_if;
  logic                             valid;
  logic                             ready;
  logic                             func_out;
  logic [hcc_pkg::CODE_W-1:0]       code_out;
  logic [hcc_pkg::LETTER_OUT_W-1:0] letter_out;

  modport source (output valid, func_out, code_out, letter_out, input ready);
  modport sink   (input valid, func_out, code_out, letter_out, output ready);
endinterface

interface hcc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hcc_pkg::CFG_IDX_W-1:0]  index;
  logic [hcc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/hcc_decode.sv
`default_nettype none

module hcc_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire hcc_pkg::item_t    item_i,
  output hcc_pkg::stage_a_t      a_o
);

  hcc_pkg::stage_a_t                a_d, a_q;
  logic [hcc_pkg::IDX_W-1:0]        p;
  logic                             found;
  logic                             keep;
  logic [hcc_pkg::PAD_W-1:0]        rnd_ext;
  logic [3:0]                       nib;
  logic [hcc_pkg::SUM_W-1:0]        s29, s28;
  logic [hcc_pkg::PROD_W-1:0]       prod;

  always_comb begin
    // alphabet index of the letter, entries are distinct
    p     = '0;
    found = 1'b0;
    for (int i = 0; i < hcc_pkg::ALPHA_N; i++) begin
      if (item_i.letter_in == hcc_pkg::ALPHA[i]) begin
        p     = hcc_pkg::IDX_W'(i);
        found = 1'b1;
      end
    end

    // nibble-weighted residues of the random word
    rnd_ext = hcc_pkg::PAD_W'(item_i.random_word);
    s29     = '0;
    s28     = '0;
    for (int i = 0; i < hcc_pkg::NIB_N; i++) begin
      nib = rnd_ext[4*i +: 4];
      s29 = s29 + hcc_pkg::SUM_W'(nib) * hcc_pkg::SUM_W'(hcc_pkg::W29[i]);
      s28 = s28 + hcc_pkg::SUM_W'(nib) * hcc_pkg::SUM_W'(hcc_pkg::W28[i]);
    end

    prod = hcc_pkg::PROD_W'(item_i.code_in) * hcc_pkg::PROD_W'(hcc_pkg::RECIP_35);

    keep = (item_i.func == hcc_pkg::FUNC_DECRYPT)
         ? (item_i.code_in <= hcc_pkg::CODE_W'(hcc_pkg::CODE_MAX))
         : found;

    a_d.valid = valid_i && keep;
    a_d.func  = item_i.func;
    a_d.p     = p;
    a_d.sel29 = (p <= hcc_pkg::IDX_W'(hcc_pkg::P_SPLIT));
    a_d.s29   = s29;
    a_d.s28   = s28;
    a_d.m_dec = prod[hcc_pkg::RECIP_SHIFT +: hcc_pkg::BLK_W];
    a_d.code  = item_i.code_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else if (en_i) begin
      a_q <= a_d;
    end
  end

  assign a_o = a_q;

endmodule

`default_nettype wire

### hdl/hcc_reduce.sv
`default_nettype none

module hcc_reduce (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hcc_pkg::en_t      en_i,
  input  wire hcc_pkg::stage_a_t a_i,
  output hcc_pkg::stage_b_t      b_o,
  output hcc_pkg::stage_c_t      c_o
);

  hcc_pkg::stage_b_t            b_d, b_q;
  hcc_pkg::stage_c_t            c_d, c_q;
  logic [hcc_pkg::T_W-1:0]      t29, t28;
  logic [hcc_pkg::CODE_W-1:0]   jw;
  logic [hcc_pkg::FOLD_W-1:0]   r29, r28;
  logic [hcc_pkg::BLK_W-1:0]    rem, top, m_enc;

  // fold the residue sums twice by 64 mod n
  always_comb begin
    t29 = hcc_pkg::T_W'(a_i.s29[hcc_pkg::SUM_W-1:6]) * hcc_pkg::T_W'(hcc_pkg::FOLD29)
        + hcc_pkg::T_W'(a_i.s29[5:0]);
    t28 = hcc_pkg::T_W'(a_i.s28[hcc_pkg::SUM_W-1:6]) * hcc_pkg::T_W'(hcc_pkg::FOLD28)
        + hcc_pkg::T_W'(a_i.s28[5:0]);
    jw  = a_i.code - hcc_pkg::CODE_W'(a_i.m_dec) * hcc_pkg::CODE_W'(hcc_pkg::ALPHA_N);

    b_d.valid = a_i.valid;
    b_d.func  = a_i.func;
    b_d.p     = a_i.p;
    b_d.sel29 = a_i.sel29;
    b_d.f29   = hcc_pkg::FOLD_W'(t29[hcc_pkg::T_W-1:6]) * hcc_pkg::FOLD_W'(hcc_pkg::FOLD29)
              + hcc_pkg::FOLD_W'(t29[5:0]);
    b_d.f28   = hcc_pkg::FOLD_W'(t28[hcc_pkg::T_W-1:6]) * hcc_pkg::FOLD_W'(hcc_pkg::FOLD28)
              + hcc_pkg::FOLD_W'(t28[5:0]);
    b_d.m_dec = a_i.m_dec;
    b_d.j     = jw[hcc_pkg::IDX_W-1:0];
  end

  // final reduction and block pick
  always_comb begin
    r29 = b_q.f29;
    if (r29 >= hcc_pkg::FOLD_W'(2 * hcc_pkg::MOD_HI)) r29 = r29 - hcc_pkg::FOLD_W'(2 * hcc_pkg::MOD_HI);
    if (r29 >= hcc_pkg::FOLD_W'(hcc_pkg::MOD_HI))     r29 = r29 - hcc_pkg::FOLD_W'(hcc_pkg::MOD_HI);
    r28 = b_q.f28;
    if (r28 >= hcc_pkg::FOLD_W'(2 * hcc_pkg::MOD_LO)) r28 = r28 - hcc_pkg::FOLD_W'(2 * hcc_pkg::MOD_LO);
    if (r28 >= hcc_pkg::FOLD_W'(hcc_pkg::MOD_LO))     r28 = r28 - hcc_pkg::FOLD_W'(hcc_pkg::MOD_LO);

    rem   = b_q.sel29 ? r29[hcc_pkg::BLK_W-1:0] : r28[hcc_pkg::BLK_W-1:0];
    top   = b_q.sel29 ? hcc_pkg::BLK_W'(hcc_pkg::TOP_HI) : hcc_pkg::BLK_W'(hcc_pkg::TOP_LO);
    m_enc = top - rem;

    c_d.valid = b_q.valid;
    c_d.func  = b_q.func;
    c_d.m     = (b_q.func == hcc_pkg::FUNC_DECRYPT) ? b_q.m_dec : m_enc;
    c_d.pos   = (b_q.func == hcc_pkg::FUNC_DECRYPT) ? b_q.j : b_q.p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (en_i.b) begin
      b_q <= b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else if (en_i.c) begin
      c_q <= c_d;
    end
  end

  assign b_o = b_q;
  assign c_o = c_q;

endmodule

`default_nettype wire

### hdl/hcc_map.sv
`default_nettype none

module hcc_map (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire hcc_pkg::key_t     key_i,
  input  wire hcc_pkg::stage_c_t c_i,
  output hcc_pkg::stage_d_t      d_o,
  output hcc_pkg::res_t          res_o
);

  hcc_pkg::stage_d_t               d_d, d_q;
  logic [hcc_pkg::KEY_LEN_W-1:0]   eff_len;
  logic [hcc_pkg::IDX_W-1:0]       k_raw;
  logic [hcc_pkg::IDX_W:0]         diff, sum;
  logic [hcc_pkg::IDX_W-1:0]       off, idx;
  logic [hcc_pkg::CODE_W-1:0]      code;
  logic [hcc_pkg::LETTER_W-1:0]    letter;

  // key letter of the block
  always_comb begin
    eff_len = (key_i.len > hcc_pkg::KEY_LEN_W'(hcc_pkg::KEY_MAX))
            ? hcc_pkg::KEY_LEN_W'(hcc_pkg::KEY_MAX) : key_i.len;
    k_raw   = (c_i.m < hcc_pkg::BLK_W'(hcc_pkg::KEY_MAX)) ? key_i.letters[c_i.m] : '0;

    d_d.valid = c_i.valid;
    d_d.func  = c_i.func;
    d_d.m     = c_i.m;
    d_d.pos   = c_i.pos;
    d_d.k     = (k_raw >= hcc_pkg::IDX_W'(hcc_pkg::ALPHA_N))
              ? k_raw - hcc_pkg::IDX_W'(hcc_pkg::ALPHA_N) : k_raw;
    d_d.keyed = (c_i.m < eff_len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q <= '0;
    end else if (en_i) begin
      d_q <= d_d;
    end
  end

  // shift within the alphabet, then code or letter
  always_comb begin
    diff = (hcc_pkg::IDX_W+1)'(d_q.pos) + (hcc_pkg::IDX_W+1)'(hcc_pkg::ALPHA_N)
         - (hcc_pkg::IDX_W+1)'(d_q.k);
    if (diff >= (hcc_pkg::IDX_W+1)'(hcc_pkg::ALPHA_N)) begin
      diff = diff - (hcc_pkg::IDX_W+1)'(hcc_pkg::ALPHA_N);
    end
    sum = (hcc_pkg::IDX_W+1)'(d_q.pos) + (hcc_pkg::IDX_W+1)'(d_q.k);
    if (sum >= (hcc_pkg::IDX_W+1)'(hcc_pkg::ALPHA_N)) begin
      sum = sum - (hcc_pkg::IDX_W+1)'(hcc_pkg::ALPHA_N);
    end
    off    = d_q.keyed ? diff[hcc_pkg::IDX_W-1:0] : d_q.pos;
    idx    = d_q.keyed ? sum[hcc_pkg::IDX_W-1:0] : d_q.pos;
    code   = hcc_pkg::CODE_W'(d_q.m) * hcc_pkg::CODE_W'(hcc_pkg::ALPHA_N)
           + hcc_pkg::CODE_W'(off);
    letter = hcc_pkg::ALPHA[idx];

    res_o.valid  = d_q.valid;
    res_o.func   = d_q.func;
    res_o.code   = (d_q.func == hcc_pkg::FUNC_DECRYPT) ? '0 : code;
    res_o.letter = (d_q.func == hcc_pkg::FUNC_DECRYPT)
                 ? letter[hcc_pkg::LETTER_OUT_W-1:0] : '0;
  end

  assign d_o = d_q;

endmodule

`default_nettype wire

### hdl/homophonic_cipher_codec_top.sv
// channel  | dir | handshake    | payload
// ---------+-----+--------------+------------------------------------------
// in_i     | in  | valid/ready  | func, letter_in, code_in, random_word
// out_o    | out | valid/ready  | func_out, code_out, letter_out
// cfg_i    | in  | valid/ready  | index (register number), data
//
// one item per cycle while out_o is ready; each transaction passes
// through stages a, b, c, d and the output register, each loaded under
// its own enable
// an item that has no result (letter outside the alphabet, code above 999)
// is dropped when it enters stage a
// reset empties the pipeline and loads key length 2 and all-zero key letters
// a stall at the output fills bubbles first, then holds each stage in place

`include "homophonic_cipher_codec_top_macros.svh"

`default_nettype none

module homophonic_cipher_codec_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hcc_in_if.sink     in_i,
  hcc_out_if.source  out_o,
  hcc_cfg_if.sink    cfg_i
);

  // configuration registers
  logic [hcc_pkg::KEY_LEN_W-1:0]  key_len_q;
  logic [hcc_pkg::KEY_LOW_W-1:0]  key_low_q;
  logic [hcc_pkg::KEY_MID_W-1:0]  key_mid_q;
  logic [hcc_pkg::KEY_HIGH_W-1:0] key_high_q;
  hcc_pkg::key_t                  key;

  // pipeline
  hcc_pkg::item_t     item;
  hcc_pkg::en_t       en;
  logic               en_out;
  hcc_pkg::stage_a_t  st_a;
  hcc_pkg::stage_b_t  st_b;
  hcc_pkg::stage_c_t  st_c;
  hcc_pkg::stage_d_t  st_d;
  hcc_pkg::res_t      res;

  // output register
  logic                             out_v_q;
  logic                             out_func_q;
  logic [hcc_pkg::CODE_W-1:0]       out_code_q;
  logic [hcc_pkg::LETTER_OUT_W-1:0] out_letter_q;

  // config writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q  <= hcc_pkg::KEY_LEN_W'(hcc_pkg::KEY_LEN_RESET);
      key_low_q  <= '0;
      key_mid_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (hcc_pkg::cfg_reg_e'(cfg_i.index))
        hcc_pkg::CFG_KEY_LENGTH: key_len_q  <= cfg_i.data[hcc_pkg::KEY_LEN_W-1:0];
        hcc_pkg::CFG_KEY_LOW:    key_low_q  <= cfg_i.data[hcc_pkg::KEY_LOW_W-1:0];
        hcc_pkg::CFG_KEY_MID:    key_mid_q  <= cfg_i.data[hcc_pkg::KEY_MID_W-1:0];
        hcc_pkg::CFG_KEY_HIGH:   key_high_q <= cfg_i.data[hcc_pkg::KEY_HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  // key letter 0 sits in the lowest bits
  assign key.len     = key_len_q;
  assign key.letters = {key_high_q, key_mid_q, key_low_q};

  // each stage loads when it is empty or its successor moves on
  assign en_out = !out_v_q || out_o.ready;
  assign en.d   = !st_d.valid || en_out;
  assign en.c   = !st_c.valid || en.d;
  assign en.b   = !st_b.valid || en.c;
  assign en.a   = !st_a.valid || en.b;

  assign in_i.ready = en.a;

  assign item.func        = in_i.func;
  assign item.letter_in   = in_i.letter_in;
  assign item.code_in     = in_i.code_in;
  assign item.random_word = in_i.random_word;

  // stage a: letter lookup, random residues, code block estimate
  hcc_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en.a),
    .valid_i (in_i.valid),
    .item_i  (item),
    .a_o     (st_a)
  );

  // stages b and c: residue folding and block selection
  hcc_reduce u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .a_i    (st_a),
    .b_o    (st_b),
    .c_o    (st_c)
  );

  // stage d: key letter, then code or letter mapping
  hcc_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en.d),
    .key_i  (key),
    .c_i    (st_c),
    .d_o    (st_d),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_out) begin
      out_v_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_func_q   <= res.func;
      out_code_q   <= res.code;
      out_letter_q <= res.letter;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.func_out   = out_func_q;
  assign out_o.code_out   = out_code_q;
  assign out_o.letter_out = out_letter_q;

  // a valid code to decrypt always enters stage a
  `HCC_ASSERT_NEXT(a_dec_enters, clk_i, rst_ni,
    in_i.valid && in_i.ready && (in_i.func == hcc_pkg::FUNC_DECRYPT) && (in_i.code_in <= hcc_pkg::CODE_W'(hcc_pkg::CODE_MAX)),
    st_a.valid, "valid decrypt transaction did not enter stage a")

  // a held stage c keeps its item
  `HCC_ASSERT_NEXT(a_stage_c_holds, clk_i, rst_ni,
    st_c.valid && !en.d,
    st_c.valid && $stable(st_c.m) && $stable(st_c.pos), "stage c lost its item under stall")

  // decrypt results carry a real letter and no code
  `HCC_ASSERT_NOW(a_dec_result, clk_i, rst_ni,
    out_v_q && (out_func_q == hcc_pkg::FUNC_DECRYPT),
    (out_code_q == '0) && (out_letter_q >= hcc_pkg::LETTER_OUT_W'(hcc_pkg::ALPHA[0])),
    "decrypt result malformed")

  // encrypt results stay in the code space and carry no letter
  `HCC_ASSERT_NOW(a_enc_result, clk_i, rst_ni,
    out_v_q && (out_func_q == hcc_pkg::FUNC_ENCRYPT),
    (out_letter_q == '0) && (out_code_q <= hcc_pkg::CODE_W'(hcc_pkg::CODE_MAX)),
    "encrypt result malformed")

endmodule

`default_nettype wire
